@@ src/tjpc_pkg.sv @@
// Shared constants, register index codes and the arctangent step table
// for the touch joystick polar clamp. No dependencies.
package tjpc_pkg;

   localparam int COORD_BITS_DEF   = 12;
   localparam int CORDIC_STEPS_DEF = 16;

   localparam int CX_W     = 12;
   localparam int R_W      = 11;
   localparam int R_RESET  = 64;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam int ANG_TAB_LEN = 24;
   localparam int ANG_W       = 18;
   localparam int ANG_MAX     = 32767;
   localparam int ANG_MIN     = -32768;
   localparam int ANG_QUARTER = 16384;

   localparam int DIR_W      = 16;
   localparam int DIR_FRAC   = 14;
   localparam int DIR_ONE    = 16384;
   localparam int ROUND_HALF = 8192;
   localparam int ANGLE_W    = 16;
   localparam int DRIVE_W    = 16;
   localparam int THUMB_W    = 14;

   localparam int QUOT_W = 16;
   localparam int RAD_W  = 64;
   localparam int ROOT_W = 32;

   typedef enum logic [1:0] {
      CSR_CENTER_X = 2'd0,
      CSR_CENTER_Y = 2'd1,
      CSR_RADIUS   = 2'd2
   } csr_index_type;

   // atan(2^-i) with pi = 32768
   function automatic logic signed [ANG_W-1:0] ang_step(input int idx);
      case (idx)
         0: begin
            ang_step = 18'sd8192;
         end
         1: begin
            ang_step = 18'sd4836;
         end
         2: begin
            ang_step = 18'sd2555;
         end
         3: begin
            ang_step = 18'sd1297;
         end
         4: begin
            ang_step = 18'sd651;
         end
         5: begin
            ang_step = 18'sd326;
         end
         6: begin
            ang_step = 18'sd163;
         end
         7: begin
            ang_step = 18'sd81;
         end
         8: begin
            ang_step = 18'sd41;
         end
         9: begin
            ang_step = 18'sd20;
         end
         10: begin
            ang_step = 18'sd10;
         end
         11: begin
            ang_step = 18'sd5;
         end
         12: begin
            ang_step = 18'sd3;
         end
         13: begin
            ang_step = 18'sd1;
         end
         14: begin
            ang_step = 18'sd1;
         end
         default: begin
            ang_step = 18'sd0;
         end
      endcase
   endfunction

endpackage

@@ src/touch_joystick_polar_clamp.sv @@
// Virtual joystick with radial clamp: one touch point in, one result word out.
// Top level; uses tjpc_pkg, tjpc_delay, tjpc_isqrt, tjpc_divider, tjpc_cordic.
//
// A word is taken on every clock where start is high (busy is always low) and its
// result appears on the rsp_ ports with rsp_strobe; a new word may enter every
// cycle, so throughput is one word per clock. The path runs through offset,
// squares and distance, the square root (two radicand bits per stage), numerator
// setup, division (one quotient bit per stage) and scaling and clamping. The
// result is not held: the receiver must take it in the strobe cycle. Write
// registers only while idle.
module touch_joystick_polar_clamp #(
   parameter int COORD_BITS   = tjpc_pkg::COORD_BITS_DEF,
   parameter int CORDIC_STEPS = tjpc_pkg::CORDIC_STEPS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [COORD_BITS-1:0]                 req_touch_x,
   input  logic [COORD_BITS-1:0]                 req_touch_y,
   input  logic                                  req_released,
   output logic                                  rsp_strobe,
   output logic                                  rsp_touching,
   output logic signed [tjpc_pkg::DIR_W-1:0]     rsp_dir_x,
   output logic signed [tjpc_pkg::DIR_W-1:0]     rsp_dir_y,
   output logic signed [tjpc_pkg::ANGLE_W-1:0]   rsp_angle_code,
   output logic signed [tjpc_pkg::THUMB_W-1:0]   rsp_thumb_x,
   output logic signed [tjpc_pkg::THUMB_W-1:0]   rsp_thumb_y,
   output logic [tjpc_pkg::DRIVE_W-1:0]          rsp_drive_level,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [tjpc_pkg::CSR_ADDR_W-1:0]       paddr,
   input  logic [tjpc_pkg::CSR_DATA_W-1:0]       pwdata,
   output logic [tjpc_pkg::CSR_DATA_W-1:0]       prdata,
   output logic                                  pready
);

   localparam int CX_W    = tjpc_pkg::CX_W;
   localparam int R_W     = tjpc_pkg::R_W;
   localparam int DIR_W   = tjpc_pkg::DIR_W;
   localparam int ANG_W   = tjpc_pkg::ANG_W;
   localparam int ANGLE_W = tjpc_pkg::ANGLE_W;
   localparam int THUMB_W = tjpc_pkg::THUMB_W;
   localparam int DRIVE_W = tjpc_pkg::DRIVE_W;
   localparam int QUOT_W  = tjpc_pkg::QUOT_W;
   localparam int RAD_W   = tjpc_pkg::RAD_W;
   localparam int ROOT_W  = tjpc_pkg::ROOT_W;
   localparam int DW_DATA = tjpc_pkg::CSR_DATA_W;

   localparam int DIST_FRAC = 31 - COORD_BITS;
   localparam int SPAN   = (COORD_BITS > CX_W) ? COORD_BITS : CX_W;
   localparam int DW     = SPAN + 1;
   localparam int SQ_W   = 2 * SPAN;
   localparam int D2W    = 2 * SPAN + 1;
   localparam int R2_W   = 2 * R_W;
   localparam int CMPD_W = (D2W > R2_W) ? D2W : R2_W;
   localparam int RDEN_W = R_W + DIST_FRAC;
   localparam int PROD_W = DIR_W + R_W + 1;
   localparam int NSTEP  = (CORDIC_STEPS > tjpc_pkg::ANG_TAB_LEN) ?
                           tjpc_pkg::ANG_TAB_LEN : CORDIC_STEPS;
   localparam int L_COR  = NSTEP + 1;
   localparam int L_SQRT = ROOT_W;
   localparam int L_DIV  = QUOT_W + 1;
   localparam int LATENCY = 3 + L_SQRT + 1 + L_DIV + 3;
   localparam int COR_PAD = LATENCY - 4 - L_COR;
   localparam int SB_W   = 5 + 2 * DW + 2 * THUMB_W;

   // configuration
   logic [CX_W-1:0] cx_ff, cy_ff;
   logic [R_W-1:0]  r_ff;
   logic [R2_W-1:0] r2_ff;
   logic            csr_wr;
   tjpc_pkg::csr_index_type csr_idx;

   assign pready  = 1'b1;
   assign busy    = 1'b0;
   assign csr_wr  = psel & penable & pwrite;
   assign csr_idx = tjpc_pkg::csr_index_type'(paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff <= '0;
         cy_ff <= '0;
         r_ff  <= R_W'(tjpc_pkg::R_RESET);
      end else if (csr_wr) begin
         case (csr_idx)
            tjpc_pkg::CSR_CENTER_X: begin
               cx_ff <= pwdata[CX_W-1:0];
            end
            tjpc_pkg::CSR_CENTER_Y: begin
               cy_ff <= pwdata[CX_W-1:0];
            end
            tjpc_pkg::CSR_RADIUS: begin
               r_ff <= pwdata[R_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         tjpc_pkg::CSR_CENTER_X: begin
            prdata = DW_DATA'(cx_ff);
         end
         tjpc_pkg::CSR_CENTER_Y: begin
            prdata = DW_DATA'(cy_ff);
         end
         tjpc_pkg::CSR_RADIUS: begin
            prdata = DW_DATA'(r_ff);
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      r2_ff <= r_ff * r_ff;
   end

   // stage 1: offsets
   logic                v1_ff, rel1_ff;
   logic signed [DW-1:0] dx1_ff, dy1_ff;
   logic [THUMB_W-1:0]  tx1_ff, ty1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= start & ~busy;
      end
      rel1_ff <= req_released;
      dx1_ff  <= $signed({1'b0, SPAN'(req_touch_x)}) - $signed({1'b0, SPAN'(cx_ff)});
      dy1_ff  <= $signed({1'b0, SPAN'(req_touch_y)}) - $signed({1'b0, SPAN'(cy_ff)});
      tx1_ff  <= THUMB_W'(req_touch_x);
      ty1_ff  <= THUMB_W'(req_touch_y);
   end

   // stage 2: squares
   logic [SPAN-1:0]     magx1, magy1;
   logic                v2_ff, rel2_ff;
   logic signed [DW-1:0] dx2_ff, dy2_ff;
   logic [THUMB_W-1:0]  tx2_ff, ty2_ff;
   logic [SQ_W-1:0]     sqx2_ff, sqy2_ff;

   assign magx1 = dx1_ff[DW-1] ? SPAN'(-dx1_ff) : SPAN'(dx1_ff);
   assign magy1 = dy1_ff[DW-1] ? SPAN'(-dy1_ff) : SPAN'(dy1_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      rel2_ff <= rel1_ff;
      dx2_ff  <= dx1_ff;
      dy2_ff  <= dy1_ff;
      tx2_ff  <= tx1_ff;
      ty2_ff  <= ty1_ff;
      sqx2_ff <= magx1 * magx1;
      sqy2_ff <= magy1 * magy1;
   end

   // stage 3: squared distance and radius compares
   logic [D2W-1:0]      d2_in, d2_3_ff;
   logic                v3_ff, rel3_ff, le3_ff, ge3_ff, zero3_ff;
   logic signed [DW-1:0] dx3_ff, dy3_ff;
   logic [THUMB_W-1:0]  tx3_ff, ty3_ff;

   assign d2_in = D2W'(sqx2_ff) + D2W'(sqy2_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
      rel3_ff  <= rel2_ff;
      le3_ff   <= CMPD_W'(d2_in) <= CMPD_W'(r2_ff);
      ge3_ff   <= CMPD_W'(d2_in) >= CMPD_W'(r2_ff);
      zero3_ff <= d2_in == '0;
      d2_3_ff  <= d2_in;
      dx3_ff   <= dx2_ff;
      dy3_ff   <= dy2_ff;
      tx3_ff   <= tx2_ff;
      ty3_ff   <= ty2_ff;
   end

   // square root of d2 scaled to the distance fraction
   logic [RAD_W-1:0]  radicand;
   logic [ROOT_W-1:0] q35;

   assign radicand = RAD_W'(d2_3_ff) << (2 * DIST_FRAC);

   tjpc_isqrt u_isqrt (
      .clock    (clock),
      .radicand (radicand),
      .root     (q35)
   );

   logic [SB_W-1:0] sb3, sb35, sb36_ff, sb53;

   assign sb3 = {v3_ff, rel3_ff, le3_ff, ge3_ff, zero3_ff,
                 dx3_ff, dy3_ff, tx3_ff, ty3_ff};

   tjpc_delay #(.WIDTH(SB_W), .DEPTH(L_SQRT)) u_sb_sqrt (
      .clock (clock),
      .reset (reset),
      .d     (sb3),
      .q     (sb35)
   );

   // stage 36: division operands
   logic signed [DW-1:0] dx35, dy35;
   logic [SPAN-1:0]      magx35, magy35;
   logic [RAD_W-1:0]     numx36_ff, numy36_ff;
   logic [ROOT_W-1:0]    q36_ff;
   logic [ROOT_W+QUOT_W-1:0] dnum36_ff;
   logic [RDEN_W-1:0]    rden;

   assign dx35   = $signed(sb35[2*THUMB_W+2*DW-1 -: DW]);
   assign dy35   = $signed(sb35[2*THUMB_W+DW-1 -: DW]);
   assign magx35 = dx35[DW-1] ? SPAN'(-dx35) : SPAN'(dx35);
   assign magy35 = dy35[DW-1] ? SPAN'(-dy35) : SPAN'(dy35);
   assign rden   = RDEN_W'(r_ff) << DIST_FRAC;

   always_ff @(posedge clock) begin
      if (reset) begin
         sb36_ff <= '0;
      end else begin
         sb36_ff <= sb35;
      end
      numx36_ff <= (RAD_W'(magx35) << (DIR_W - 2 + DIST_FRAC)) + RAD_W'(q35 >> 1);
      numy36_ff <= (RAD_W'(magy35) << (DIR_W - 2 + DIST_FRAC)) + RAD_W'(q35 >> 1);
      q36_ff    <= q35;
      dnum36_ff <= {q35, QUOT_W'(0)};
   end

   logic [QUOT_W-1:0] xq53, yq53, dq53;
   logic              xovf53, yovf53, dovf53;

   tjpc_divider #(.NUM_W(RAD_W), .DEN_W(ROOT_W)) u_div_x (
      .clock (clock),
      .num   (numx36_ff),
      .den   (q36_ff),
      .quot  (xq53),
      .ovf   (xovf53)
   );

   tjpc_divider #(.NUM_W(RAD_W), .DEN_W(ROOT_W)) u_div_y (
      .clock (clock),
      .num   (numy36_ff),
      .den   (q36_ff),
      .quot  (yq53),
      .ovf   (yovf53)
   );

   tjpc_divider #(.NUM_W(ROOT_W + QUOT_W), .DEN_W(RDEN_W)) u_div_drive (
      .clock (clock),
      .num   (dnum36_ff),
      .den   (rden),
      .quot  (dq53),
      .ovf   (dovf53)
   );

   tjpc_delay #(.WIDTH(SB_W), .DEPTH(L_DIV)) u_sb_div (
      .clock (clock),
      .reset (reset),
      .d     (sb36_ff),
      .q     (sb53)
   );

   // angle runs beside the distance path
   logic signed [ANG_W-1:0] cz, cz53;

   tjpc_cordic #(.IN_W(DW), .STEPS(NSTEP)) u_cordic (
      .clock (clock),
      .dx    (dx1_ff),
      .dy    (dy1_ff),
      .angle (cz)
   );

   tjpc_delay #(.WIDTH(ANG_W), .DEPTH(COR_PAD)) u_ang_pad (
      .clock (clock),
      .reset (reset),
      .d     (cz),
      .q     (cz53)
   );

   // stage 54: direction, drive, angle
   logic                v53, rel53, le53, ge53, zero53;
   logic signed [DW-1:0] dx53, dy53;
   logic [THUMB_W-1:0]  tx53, ty53;
   logic [QUOT_W-1:0]   mx53, my53;
   logic signed [DIR_W-1:0]   dirx_in, diry_in;
   logic signed [ANGLE_W-1:0] ang_in;
   logic [DRIVE_W-1:0]  drive_in;

   assign {v53, rel53, le53, ge53, zero53, dx53, dy53, tx53, ty53} = sb53;

   assign mx53 = (xovf53 || xq53 > QUOT_W'(tjpc_pkg::DIR_ONE)) ?
                 QUOT_W'(tjpc_pkg::DIR_ONE) : xq53;
   assign my53 = (yovf53 || yq53 > QUOT_W'(tjpc_pkg::DIR_ONE)) ?
                 QUOT_W'(tjpc_pkg::DIR_ONE) : yq53;

   always_comb begin
      if (zero53) begin
         dirx_in = '0;
         diry_in = DIR_W'(tjpc_pkg::DIR_ONE);
         ang_in  = '0;
      end else begin
         dirx_in = dx53[DW-1] ? -$signed(mx53) : $signed(mx53);
         diry_in = dy53[DW-1] ? -$signed(my53) : $signed(my53);
         if (cz53 > ANG_W'(tjpc_pkg::ANG_MAX)) begin
            ang_in = ANGLE_W'(tjpc_pkg::ANG_MAX);
         end else if (cz53 < ANG_W'(tjpc_pkg::ANG_MIN)) begin
            ang_in = ANGLE_W'(tjpc_pkg::ANG_MIN);
         end else begin
            ang_in = ANGLE_W'(cz53);
         end
      end
      drive_in = (ge53 || dovf53) ? '1 : dq53;
   end

   logic                      v54_ff, touch54_ff, gt54_ff;
   logic signed [DIR_W-1:0]   dirx54_ff, diry54_ff;
   logic signed [ANGLE_W-1:0] ang54_ff;
   logic [DRIVE_W-1:0]        drive54_ff;
   logic [THUMB_W-1:0]        tx54_ff, ty54_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v54_ff <= 1'b0;
      end else begin
         v54_ff <= v53;
      end
      touch54_ff <= le53 & ~rel53;
      gt54_ff    <= ~le53;
      dirx54_ff  <= dirx_in;
      diry54_ff  <= diry_in;
      ang54_ff   <= ang_in;
      drive54_ff <= drive_in;
      tx54_ff    <= tx53;
      ty54_ff    <= ty53;
   end

   // stage 55: direction times radius
   logic                      v55_ff, touch55_ff, gt55_ff;
   logic signed [DIR_W-1:0]   dirx55_ff, diry55_ff;
   logic signed [ANGLE_W-1:0] ang55_ff;
   logic [DRIVE_W-1:0]        drive55_ff;
   logic [THUMB_W-1:0]        tx55_ff, ty55_ff;
   logic signed [PROD_W-1:0]  px55_ff, py55_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v55_ff <= 1'b0;
      end else begin
         v55_ff <= v54_ff;
      end
      touch55_ff <= touch54_ff;
      gt55_ff    <= gt54_ff;
      dirx55_ff  <= dirx54_ff;
      diry55_ff  <= diry54_ff;
      ang55_ff   <= ang54_ff;
      drive55_ff <= drive54_ff;
      tx55_ff    <= tx54_ff;
      ty55_ff    <= ty54_ff;
      px55_ff    <= dirx54_ff * $signed({1'b0, r_ff});
      py55_ff    <= diry54_ff * $signed({1'b0, r_ff});
   end

   // stage 56: thumb clamp, output register
   logic signed [PROD_W-1:0] shx, shy;
   logic [THUMB_W-1:0]       thx_in, thy_in, thx56_ff, thy56_ff;
   logic                     v56_ff, touch56_ff;
   logic signed [DIR_W-1:0]  dirx56_ff, diry56_ff;
   logic signed [ANGLE_W-1:0] ang56_ff;
   logic [DRIVE_W-1:0]       drive56_ff;

   assign shx    = (px55_ff + PROD_W'(tjpc_pkg::ROUND_HALF)) >>> tjpc_pkg::DIR_FRAC;
   assign shy    = (py55_ff + PROD_W'(tjpc_pkg::ROUND_HALF)) >>> tjpc_pkg::DIR_FRAC;
   assign thx_in = gt55_ff ? THUMB_W'(cx_ff) + shx[THUMB_W-1:0] : tx55_ff;
   assign thy_in = gt55_ff ? THUMB_W'(cy_ff) + shy[THUMB_W-1:0] : ty55_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v56_ff <= 1'b0;
      end else begin
         v56_ff <= v55_ff;
      end
      touch56_ff <= touch55_ff;
      dirx56_ff  <= dirx55_ff;
      diry56_ff  <= diry55_ff;
      ang56_ff   <= ang55_ff;
      drive56_ff <= drive55_ff;
      thx56_ff   <= thx_in;
      thy56_ff   <= thy_in;
   end

   assign rsp_strobe      = v56_ff;
   assign rsp_touching    = touch56_ff;
   assign rsp_dir_x       = dirx56_ff;
   assign rsp_dir_y       = diry56_ff;
   assign rsp_angle_code  = ang56_ff;
   assign rsp_thumb_x     = $signed(thx56_ff);
   assign rsp_thumb_y     = $signed(thy56_ff);
   assign rsp_drive_level = drive56_ff;

   a_latency : assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##LATENCY rsp_strobe)
      else $error("word accepted but no result at fixed latency");

   a_no_spurious : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, LATENCY))
      else $error("result word without an accepted input word");

   a_dir_range : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_dir_x <= 16'sd16384 && rsp_dir_x >= -16'sd16384 &&
                      rsp_dir_y <= 16'sd16384 && rsp_dir_y >= -16'sd16384))
      else $error("direction component beyond unit length");

endmodule

@@ src/tjpc_delay.sv @@
// Register delay line for words that ride alongside the arithmetic units.
// Uses nothing from the package.
module tjpc_delay #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [WIDTH-1:0] d,
   output logic [WIDTH-1:0] q
);

   logic [WIDTH-1:0] data_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            data_ff[i] <= '0;
         end
      end else begin
         data_ff[0] <= d;
         for (int i = 1; i < DEPTH; i++) begin
            data_ff[i] <= data_ff[i-1];
         end
      end
   end

   assign q = data_ff[DEPTH-1];

endmodule

@@ src/tjpc_isqrt.sv @@
// Pipelined integer square root, two radicand bits per stage.
// Depends on tjpc_pkg for the radicand and root widths.
module tjpc_isqrt (
   input  logic                        clock,
   input  logic [tjpc_pkg::RAD_W-1:0]  radicand,
   output logic [tjpc_pkg::ROOT_W-1:0] root
);

   localparam int RW    = tjpc_pkg::RAD_W;
   localparam int QW    = tjpc_pkg::ROOT_W;
   localparam int REM_W = QW + 3;

   logic [REM_W-1:0] rem_ff  [QW];
   logic [QW-1:0]    root_ff [QW];
   logic [RW-1:0]    rad_ff  [QW];

   for (genvar k = 0; k < QW; k++) begin : g_stage
      logic [REM_W-1:0] rem_prev, cand, trial, rem_in;
      logic [QW-1:0]    root_prev, root_in;
      logic [RW-1:0]    rad_prev, rad_in;

      if (k == 0) begin : g_first
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign rad_prev  = radicand;
      end else begin : g_next
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
         assign rad_prev  = rad_ff[k-1];
      end

      assign cand   = {rem_prev[REM_W-3:0], rad_prev[RW-1 -: 2]};
      assign trial  = {1'b0, root_prev, 2'b01};
      assign rad_in = {rad_prev[RW-3:0], 2'b00};

      always_comb begin
         if (cand >= trial) begin
            rem_in  = cand - trial;
            root_in = {root_prev[QW-2:0], 1'b1};
         end else begin
            rem_in  = cand;
            root_in = {root_prev[QW-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[k]  <= rem_in;
         root_ff[k] <= root_in;
         rad_ff[k]  <= rad_in;
      end
   end

   assign root = root_ff[QW-1];

endmodule

@@ src/tjpc_divider.sv @@
// Pipelined restoring divider, one quotient bit per stage, with an
// overflow flag for quotients past QUOT_W bits. Depends on tjpc_pkg.
module tjpc_divider #(
   parameter int NUM_W = 64,
   parameter int DEN_W = 32
) (
   input  logic                        clock,
   input  logic [NUM_W-1:0]            num,
   input  logic [DEN_W-1:0]            den,
   output logic [tjpc_pkg::QUOT_W-1:0] quot,
   output logic                        ovf
);

   localparam int QB    = tjpc_pkg::QUOT_W;
   localparam int HI_W  = NUM_W - QB;
   localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;

   logic [DEN_W-1:0] rem_ff [QB+1];
   logic [DEN_W-1:0] den_ff [QB+1];
   logic [QB-1:0]    low_ff [QB+1];
   logic             ovf_ff [QB+1];

   always_ff @(posedge clock) begin
      ovf_ff[0] <= CMP_W'(num[NUM_W-1:QB]) >= CMP_W'(den);
      rem_ff[0] <= DEN_W'(num[NUM_W-1:QB]);
      low_ff[0] <= num[QB-1:0];
      den_ff[0] <= den;
   end

   for (genvar k = 0; k < QB; k++) begin : g_stage
      logic [DEN_W:0]   cand;
      logic             take;
      logic [DEN_W-1:0] rem_in;
      logic [QB-1:0]    low_in;

      assign cand   = {rem_ff[k], low_ff[k][QB-1]};
      assign take   = cand >= {1'b0, den_ff[k]};
      assign rem_in = take ? DEN_W'(cand - {1'b0, den_ff[k]}) : DEN_W'(cand);
      assign low_in = {low_ff[k][QB-2:0], take};

      always_ff @(posedge clock) begin
         rem_ff[k+1] <= rem_in;
         den_ff[k+1] <= den_ff[k];
         low_ff[k+1] <= low_in;
         ovf_ff[k+1] <= ovf_ff[k];
      end
   end

   assign quot = low_ff[QB];
   assign ovf  = ovf_ff[QB];

endmodule

@@ src/tjpc_cordic.sv @@
// Pipelined vectoring CORDIC: angle of (dx, dy) from the y axis, pi = 32768.
// Quarter-turn pre-rotation stage then one micro-rotation per stage. Uses tjpc_pkg.
module tjpc_cordic #(
   parameter int IN_W  = 13,
   parameter int STEPS = 16
) (
   input  logic                              clock,
   input  logic signed [IN_W-1:0]            dx,
   input  logic signed [IN_W-1:0]            dy,
   output logic signed [tjpc_pkg::ANG_W-1:0] angle
);

   localparam int AW = tjpc_pkg::ANG_W;
   localparam int CW = IN_W + 18;

   logic signed [CW-1:0] x_ff [STEPS+1];
   logic signed [CW-1:0] y_ff [STEPS+1];
   logic signed [AW-1:0] z_ff [STEPS+1];

   logic signed [CW-1:0] xs, ys, x0_in, y0_in;
   logic signed [AW-1:0] z0_in;

   assign xs = CW'(dy) <<< 16;
   assign ys = CW'(dx) <<< 16;

   always_comb begin
      x0_in = xs;
      y0_in = ys;
      z0_in = '0;
      if (xs < 0) begin
         if (ys >= 0) begin
            x0_in = ys;
            y0_in = -xs;
            z0_in = AW'(tjpc_pkg::ANG_QUARTER);
         end else begin
            x0_in = -ys;
            y0_in = xs;
            z0_in = -AW'(tjpc_pkg::ANG_QUARTER);
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff[0] <= x0_in;
      y_ff[0] <= y0_in;
      z_ff[0] <= z0_in;
   end

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      logic signed [CW-1:0] x_in, y_in;
      logic signed [AW-1:0] z_in;

      always_comb begin
         if (y_ff[k] >= 0) begin
            x_in = x_ff[k] + (y_ff[k] >>> k);
            y_in = y_ff[k] - (x_ff[k] >>> k);
            z_in = z_ff[k] + tjpc_pkg::ang_step(k);
         end else begin
            x_in = x_ff[k] - (y_ff[k] >>> k);
            y_in = y_ff[k] + (x_ff[k] >>> k);
            z_in = z_ff[k] - tjpc_pkg::ang_step(k);
         end
      end

      always_ff @(posedge clock) begin
         x_ff[k+1] <= x_in;
         y_ff[k+1] <= y_in;
         z_ff[k+1] <= z_in;
      end
   end

   assign angle = z_ff[STEPS];

endmodule
